/* rtl/tti_pkg.sv */
// Package for the trilinear table interpolator.
// Holds the word structs, function codes, register indexes, state and command types.
// Used by every module in the rtl folder; depends on nothing.
package tti_pkg;

	localparam int VAL_W  = 16;
	localparam int IDX_W  = 4;
	localparam int FUNC_W = 3;
	localparam int CNT_W  = 5;
	localparam int REG_W  = 2;
	localparam int WGT_W  = 17;

	localparam logic [FUNC_W-1:0] FUNC_LATERAL  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_HEADING  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_STEERING = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_TABLE    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd4;

	localparam logic [REG_W-1:0] REG_LATERAL_COUNT  = 2'd0;
	localparam logic [REG_W-1:0] REG_HEADING_COUNT  = 2'd1;
	localparam logic [REG_W-1:0] REG_STEERING_COUNT = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

	localparam logic [4:0] DIV_LAST = 5'd17;
	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [2:0] BLEND_LAST = 3'd6;

	localparam logic [2:0] PH_ISSUE  = 3'd0;
	localparam logic [2:0] PH_LOAD_A = 3'd1;
	localparam logic [2:0] PH_LOAD_B = 3'd2;
	localparam logic [2:0] PH_MUL    = 3'd3;
	localparam logic [2:0] PH_SUM    = 3'd4;

	localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'h10000;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [IDX_W-1:0]        index_a;
		logic [IDX_W-1:0]        index_b;
		logic [IDX_W-1:0]        index_c;
		logic signed [VAL_W-1:0] write_value;
		logic signed [VAL_W-1:0] lateral_error;
		logic signed [VAL_W-1:0] heading_error;
		logic signed [VAL_W-1:0] steering_error;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] steering_command;
		logic                    clamped;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIV,
		ST_BLEND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       write;
		logic       load;
		logic       search;
		logic       div_init;
		logic       div_iter;
		logic       div_first;
		logic       div_last;
		logic       blend;
		logic [1:0] axis;
		logic [2:0] blend_sel;
		logic [2:0] phase;
	} ctrl_t;

endpackage

/* rtl/tti_controller.sv */
// Sequencer of the trilinear table interpolator.
// Steps the grid search, the three divisions and the seven blends; uses tti_pkg.
module tti_controller
	import tti_pkg::*;
#(
	parameter int GRID_POINTS = 16,
	parameter int CELL_W = 4,
	parameter int STEP_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	output logic              busy,
	output logic              done,
	output ctrl_t             cmd,
	output logic [CELL_W-1:0] search_index
);

	localparam logic [STEP_W-1:0] SEARCH_LAST = STEP_W'(GRID_POINTS - 1);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [1:0]        axis_q, axis_d;
	logic [2:0]        sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			axis_q  <= '0;
			sel_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			axis_q  <= axis_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		axis_d  = axis_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.axis      = axis_q;
		cmd.blend_sel = sel_q;
		cmd.phase     = step_q[2:0];
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (func == FUNC_QUERY) begin
						cmd.load = 1'b1;
						state_d  = ST_SEARCH;
						step_d   = '0;
					end else if (func <= FUNC_TABLE) begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
				if (step_q == SEARCH_LAST) begin
					state_d = ST_DIV;
					step_d  = '0;
					axis_d  = '0;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_init  = (step_q == '0);
				cmd.div_iter  = (step_q != '0);
				cmd.div_first = (step_q == STEP_W'(1));
				cmd.div_last  = (step_q == STEP_W'(DIV_LAST));
				if (step_q == STEP_W'(DIV_LAST)) begin
					step_d = '0;
					if (axis_q == AXIS_LAST) begin
						state_d = ST_BLEND;
						sel_d   = '0;
					end else begin
						axis_d = axis_q + 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_BLEND: begin
				cmd.blend = 1'b1;
				if (step_q[2:0] == PH_SUM) begin
					step_d = '0;
					if (sel_q == BLEND_LAST) begin
						state_d = ST_DONE;
					end else begin
						sel_d = sel_q + 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign search_index = step_q[CELL_W-1:0];

	a_done_after_blend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> $past(state_q) == ST_BLEND)
		else $error("result strobe without a finished blend");
	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && start && func == FUNC_QUERY |=> state_q == ST_SEARCH)
		else $error("accepted query did not start the search");
	a_div_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> step_q <= STEP_W'(DIV_LAST))
		else $error("division step out of range");
	a_blend_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BLEND |-> step_q <= STEP_W'(PH_SUM))
		else $error("blend phase out of range");

endmodule

/* rtl/tti_datapath.sv */
// Datapath of the trilinear table interpolator: grid points, command table,
// count registers, cell search, serial divider and shared blend multiplier; uses tti_pkg.
module tti_datapath
	import tti_pkg::*;
#(
	parameter int GRID_POINTS = 16,
	parameter int CELL_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  in_word_t          item,
	input  ctrl_t             cmd,
	input  logic [CELL_W-1:0] search_index,
	input  logic              reg_we,
	input  logic [REG_W-1:0]  reg_index,
	input  logic [CNT_W-1:0]  reg_data,
	output out_word_t         result
);

	localparam int NW = $clog2(GRID_POINTS + 1);
	localparam int ADDR_W = 3 * CELL_W;
	localparam int DEPTH = GRID_POINTS * GRID_POINTS * GRID_POINTS;
	localparam logic [7:0] GP8 = 8'(GRID_POINTS);

	logic [CNT_W-1:0] count_q [3];
	logic [NW-1:0]    n_eff [3];

	logic signed [VAL_W-1:0] pts_q [3][GRID_POINTS];
	logic signed [VAL_W-1:0] x_q [3];
	logic signed [VAL_W-1:0] prev_q [3];
	logic signed [VAL_W-1:0] p0_q [3];
	logic signed [VAL_W-1:0] lo_q [3];
	logic [VAL_W-1:0]        d_q [3];
	logic [CELL_W-1:0]       cell_q [3];
	logic                    found_q [3];
	logic                    clamp_q [3];
	logic [WGT_W-1:0]        w_q [3];

	logic [VAL_W:0]   r_q;
	logic [VAL_W-1:0] den_q;
	logic [VAL_W-1:0] q_q;
	logic [VAL_W:0]   r_in;
	logic             ge;
	logic signed [VAL_W:0] x_diff;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic              idx_ok;

	logic signed [VAL_W-1:0] op_a_q, op_b_q;
	logic signed [VAL_W-1:0] lerp_q [7];
	logic signed [34:0]      prod_q;
	logic signed [VAL_W-1:0] sel_a, sel_b;
	logic [WGT_W-1:0]        w_sel;
	logic signed [VAL_W:0]   ab_diff;
	logic signed [34:0]      rnd;
	logic signed [19:0]      total;
	logic signed [VAL_W-1:0] sat;
	logic [CELL_W-1:0]       ci, cj, ck;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (count_q[a] < 5'd2) begin
				n_eff[a] = NW'(2);
			end else if ({3'b000, count_q[a]} > GP8) begin
				n_eff[a] = NW'(GRID_POINTS);
			end else begin
				n_eff[a] = NW'(count_q[a]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				count_q[a] <= COUNT_RESET;
			end
		end else if (reg_we) begin
			case (reg_index)
				REG_LATERAL_COUNT:  count_q[0] <= reg_data;
				REG_HEADING_COUNT:  count_q[1] <= reg_data;
				REG_STEERING_COUNT: count_q[2] <= reg_data;
				default: ;
			endcase
		end
	end

	assign idx_ok = ({4'b0000, item.index_a} < GP8) && ({4'b0000, item.index_b} < GP8)
		&& ({4'b0000, item.index_c} < GP8);
	assign wr_addr = {CELL_W'(item.index_a), CELL_W'(item.index_b), CELL_W'(item.index_c)};

	always_ff @(posedge clk) begin
		if (cmd.write && item.func <= FUNC_STEERING && ({4'b0000, item.index_a} < GP8)) begin
			pts_q[item.func[1:0]][CELL_W'(item.index_a)] <= item.write_value;
		end
		if (cmd.load) begin
			x_q[0] <= item.lateral_error;
			x_q[1] <= item.heading_error;
			x_q[2] <= item.steering_error;
		end
		for (int a = 0; a < 3; a++) begin
			if (cmd.search && (NW'(search_index) < n_eff[a])) begin
				if (search_index == '0) begin
					p0_q[a]    <= pts_q[a][search_index];
					found_q[a] <= 1'b0;
				end else if (!found_q[a] && x_q[a] >= prev_q[a]
					&& x_q[a] <= pts_q[a][search_index]) begin
					found_q[a] <= 1'b1;
					cell_q[a]  <= search_index - 1'b1;
					lo_q[a]    <= prev_q[a];
					d_q[a]     <= VAL_W'(pts_q[a][search_index] - prev_q[a]);
				end
				prev_q[a] <= pts_q[a][search_index];
			end
		end
		if (cmd.div_last) begin
			clamp_q[cmd.axis] <= !found_q[cmd.axis];
			if (found_q[cmd.axis]) begin
				w_q[cmd.axis] <= (den_q == '0) ? '0 : {q_q, ge};
			end else if (x_q[cmd.axis] < p0_q[cmd.axis]) begin
				w_q[cmd.axis]    <= '0;
				cell_q[cmd.axis] <= '0;
			end else begin
				w_q[cmd.axis]    <= WEIGHT_ONE;
				cell_q[cmd.axis] <= CELL_W'(n_eff[cmd.axis] - NW'(2));
			end
		end
	end

	assign x_diff = {x_q[cmd.axis][VAL_W-1], x_q[cmd.axis]}
		- {lo_q[cmd.axis][VAL_W-1], lo_q[cmd.axis]};
	assign r_in = cmd.div_first ? r_q : {r_q[VAL_W-1:0], 1'b0};
	assign ge = (r_in >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			r_q   <= found_q[cmd.axis] ? x_diff : '0;
			den_q <= d_q[cmd.axis];
			q_q   <= '0;
		end else if (cmd.div_iter) begin
			r_q <= ge ? (r_in - {1'b0, den_q}) : r_in;
			q_q <= {q_q[VAL_W-2:0], ge};
		end
	end

	assign ci = cell_q[0] + CELL_W'(cmd.phase == PH_LOAD_A);
	assign cj = cell_q[1] + CELL_W'(cmd.blend_sel[0]);
	assign ck = cell_q[2] + CELL_W'(cmd.blend_sel[1]);
	assign rd_addr = {ci, cj, ck};

	always_ff @(posedge clk) begin
		if (cmd.write && item.func == FUNC_TABLE && idx_ok) begin
			mem[wr_addr] <= item.write_value;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		case (cmd.blend_sel)
			3'd4: begin
				sel_a = lerp_q[0];
				sel_b = lerp_q[1];
			end
			3'd5: begin
				sel_a = lerp_q[2];
				sel_b = lerp_q[3];
			end
			default: begin
				sel_a = lerp_q[4];
				sel_b = lerp_q[5];
			end
		endcase
		if (cmd.blend_sel < 3'd4) begin
			w_sel = w_q[0];
		end else if (cmd.blend_sel < 3'd6) begin
			w_sel = w_q[1];
		end else begin
			w_sel = w_q[2];
		end
	end

	assign ab_diff = {op_b_q[VAL_W-1], op_b_q} - {op_a_q[VAL_W-1], op_a_q};
	assign rnd = prod_q + 35'sd32768;
	assign total = {{4{op_a_q[VAL_W-1]}}, op_a_q} + {rnd[34], rnd[34:16]};

	always_comb begin
		if (total > 20'sd32767) begin
			sat = 16'sh7fff;
		end else if (total < -20'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = total[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.blend) begin
			case (cmd.phase)
				PH_LOAD_A: op_a_q <= (cmd.blend_sel < 3'd4) ? rd_q : sel_a;
				PH_LOAD_B: op_b_q <= (cmd.blend_sel < 3'd4) ? rd_q : sel_b;
				PH_MUL:    prod_q <= ab_diff * $signed({1'b0, w_sel});
				PH_SUM:    lerp_q[cmd.blend_sel] <= sat;
				default: ;
			endcase
		end
	end

	assign result.steering_command = lerp_q[6];
	assign result.clamped = clamp_q[0] | clamp_q[1] | clamp_q[2];

endmodule

/* rtl/trilinear_table_interpolator.sv */
// Top level of the trilinear table interpolator.
// Joins tti_controller and tti_datapath; uses tti_pkg.
//
// Input words are taken on start while busy is low. Func codes 0 to 3 write a
// grid point or a table entry in that cycle and busy stays low. A query word
// raises busy and then gives one result word on result with done high for
// exactly one cycle; the receiver cannot stall it. A query runs a search over
// the grid points of all three axes at once, three bit-serial divisions, and
// seven blends through the single table read port and the shared multiplier,
// each blend stepping through issue, load, multiply and sum phases, and then
// gives the result. The next word can be accepted in the cycle after done. The
// count registers are written through reg_we, reg_index and reg_data; the user
// must do so only while the block is idle, as the block itself does not enforce
// it. Reset sets all three counts to 16 and returns the sequencer to idle; grid
// points and the table hold no defined value until written.
module trilinear_table_interpolator
	import tti_pkg::*;
#(
	parameter int GRID_POINTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_word_t         item,
	output logic             done,
	output out_word_t        result,
	input  logic             reg_we,
	input  logic [REG_W-1:0] reg_index,
	input  logic [CNT_W-1:0] reg_data
);

	localparam int CELL_W = $clog2(GRID_POINTS);
	localparam int STEP_W = (CELL_W > 5) ? CELL_W : 5;

	ctrl_t             cmd;
	logic [CELL_W-1:0] search_index;

	tti_controller #(
		.GRID_POINTS(GRID_POINTS),
		.CELL_W(CELL_W),
		.STEP_W(STEP_W)
	) u_controller (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(item.func),
		.busy(busy),
		.done(done),
		.cmd(cmd),
		.search_index(search_index)
	);

	tti_datapath #(
		.GRID_POINTS(GRID_POINTS),
		.CELL_W(CELL_W)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.search_index(search_index),
		.reg_we(reg_we),
		.reg_index(reg_index),
		.reg_data(reg_data),
		.result(result)
	);

endmodule

/* dv/tb.sv */
// Testbench for trilinear_table_interpolator: loads grids and the command table,
// runs directed and random queries through an internal predictor and checks each result.
// Depends on rtl/tti_pkg.sv and rtl/trilinear_table_interpolator.sv.
module tb;
	import tti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GP = 16;
	localparam int LOW_POINTS = 8;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_word_t item;
	logic done;
	out_word_t result;
	logic reg_we;
	logic [REG_W-1:0] reg_index;
	logic [CNT_W-1:0] reg_data;

	trilinear_table_interpolator #(.GRID_POINTS(GP)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .reg_we(reg_we), .reg_index(reg_index),
		.reg_data(reg_data)
	);

	logic signed [VAL_W-1:0] grid_pts[3][GP];
	logic signed [VAL_W-1:0] cmd_table[GP*GP*GP];
	logic [CNT_W-1:0] axis_count[3];
	out_word_t pending_cmds[$];
	int errors = 0;
	int idle_cycles = 0;
	bit no_gaps = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int eff_count(input logic [CNT_W-1:0] c);
		if (c < 2) return 2;
		if (c > GP) return GP;
		return int'(c);
	endfunction

	function automatic bit locate_cell(input int axis, input longint x, output int cell_idx,
			output longint w);
		int n;
		longint lo;
		longint hi;
		n = eff_count(axis_count[axis]);
		for (int i = 0; i + 1 < n; i++) begin
			lo = grid_pts[axis][i];
			hi = grid_pts[axis][i+1];
			if (x >= lo && x <= hi) begin
				cell_idx = i;
				w = (hi == lo) ? 0 : ((x - lo) << 16) / (hi - lo);
				return 0;
			end
		end
		if (x < longint'(grid_pts[axis][0])) begin
			cell_idx = 0;
			w = 0;
		end else begin
			cell_idx = n - 2;
			w = 65536;
		end
		return 1;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint w);
		return (a * (65536 - w) + b * w + 32768) >>> 16;
	endfunction

	function automatic longint corner(input int i, input int j, input int k);
		return cmd_table[i*GP*GP + j*GP + k];
	endfunction

	function automatic out_word_t interpolate(input in_word_t q);
		out_word_t r;
		int i0, j0, k0;
		longint xd, yd, zd, c00, c10, c01, c11, c0, c1, v;
		bit cl;
		cl = locate_cell(0, q.lateral_error, i0, xd);
		cl |= locate_cell(1, q.heading_error, j0, yd);
		cl |= locate_cell(2, q.steering_error, k0, zd);
		c00 = blend(corner(i0, j0, k0), corner(i0+1, j0, k0), xd);
		c10 = blend(corner(i0, j0+1, k0), corner(i0+1, j0+1, k0), xd);
		c01 = blend(corner(i0, j0, k0+1), corner(i0+1, j0, k0+1), xd);
		c11 = blend(corner(i0, j0+1, k0+1), corner(i0+1, j0+1, k0+1), xd);
		c0 = blend(c00, c10, yd);
		c1 = blend(c01, c11, yd);
		v = blend(c0, c1, zd);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		r.steering_command = v[VAL_W-1:0];
		r.clamped = cl;
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input in_word_t w);
		int g;
		item = w;
		start = 1;
		do @(posedge clk); while (busy);
		case (w.func)
			FUNC_LATERAL: grid_pts[0][w.index_a] = w.write_value;
			FUNC_HEADING: grid_pts[1][w.index_a] = w.write_value;
			FUNC_STEERING: grid_pts[2][w.index_a] = w.write_value;
			FUNC_TABLE: cmd_table[w.index_a*GP*GP + w.index_b*GP + w.index_c] = w.write_value;
			FUNC_QUERY: pending_cmds.insert(pending_cmds.size(), interpolate(w));
			default: ;
		endcase
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			start = 0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic in_word_t noise_word(input logic [FUNC_W-1:0] f);
		in_word_t w;
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		w.func = f;
		return w;
	endfunction

	task automatic send_write(input logic [FUNC_W-1:0] f, input int a, input int b, input int c,
			input logic signed [VAL_W-1:0] v);
		in_word_t w;
		w = noise_word(f);
		w.index_a = IDX_W'(a);
		w.index_b = IDX_W'(b);
		w.index_c = IDX_W'(c);
		w.write_value = v;
		send_word(w);
	endtask

	task automatic send_query(input logic signed [VAL_W-1:0] x, input logic signed [VAL_W-1:0] y,
			input logic signed [VAL_W-1:0] z);
		in_word_t w;
		w = noise_word(FUNC_QUERY);
		w.lateral_error = x;
		w.heading_error = y;
		w.steering_error = z;
		send_word(w);
	endtask

	task automatic drain();
		start = 0;
		while (pending_cmds.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_count(input logic [REG_W-1:0] idx, input logic [CNT_W-1:0] v);
		drain();
		reg_we = 1;
		reg_index = idx;
		reg_data = v;
		@(negedge clk);
		reg_we = 0;
		if (idx <= REG_STEERING_COUNT) axis_count[idx] = v;
	endtask

	// Ascending grid with random spacing; when dups is set, some neighbors are made equal.
	// Points from LOW_POINTS up sit at the top of the range, so a query never
	// reaches a table index above LOW_POINTS.
	task automatic load_grid(input int axis, input bit dups);
		int v[$];
		int lo;
		int hi;
		lo = $urandom_range(0, 1) ? -32768 : -$urandom_range(0, 20000);
		hi = $urandom_range(0, 1) ? 32767 : $urandom_range(0, 20000);
		for (int i = 0; i < LOW_POINTS; i++) v.insert(v.size(), lo + $urandom_range(0, hi - lo));
		v.sort();
		if (dups) v[$urandom_range(1, 5)] = v[0];
		for (int i = 0; i < LOW_POINTS; i++) v[i] = (i > 0 && v[i] < v[i-1]) ? v[i-1] : v[i];
		for (int i = 0; i < GP; i++)
			send_write(FUNC_W'(int'(FUNC_LATERAL) + axis), i, $urandom_range(0, 15),
				$urandom_range(0, 15), VAL_W'((i < LOW_POINTS) ? v[i] : 32767));
	endtask

	function automatic logic signed [VAL_W-1:0] pick_coord(input int axis);
		int n;
		int lo;
		int hi;
		int r;
		n = eff_count(axis_count[axis]);
		lo = grid_pts[axis][0];
		hi = grid_pts[axis][n-1];
		r = $urandom_range(0, 99);
		if (r < 10) return grid_pts[axis][$urandom_range(0, n - 1)];
		if (r < 20) return VAL_W'($urandom);
		if (hi < lo) return VAL_W'($urandom);
		r = lo - 200 + $urandom_range(0, hi - lo + 400);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return VAL_W'(r);
	endfunction

	task automatic test_load_stores();
		no_gaps = 1;
		for (int a = 0; a < 3; a++) load_grid(a, 0);
		for (int i = 0; i <= LOW_POINTS; i++)
			for (int j = 0; j <= LOW_POINTS; j++)
				for (int k = 0; k <= LOW_POINTS; k++)
					send_write(FUNC_TABLE, i, j, k, VAL_W'($urandom));
		no_gaps = 0;
	endtask

	task automatic test_directed();
		send_query(grid_pts[0][0], grid_pts[1][0], grid_pts[2][0]);
		send_query(grid_pts[0][15], grid_pts[1][15], grid_pts[2][15]);
		send_query(-32768, -32768, -32768);
		send_query(32767, 32767, 32767);
		send_query(grid_pts[0][3], 32767, -32768);
		send_write(FUNC_TABLE, LOW_POINTS, LOW_POINTS, LOW_POINTS, 32767);
		send_write(FUNC_TABLE, 0, 0, 0, -32768);
		send_query(32767, 32767, 32767);
		send_query(-32768, -32768, -32768);
		for (logic [FUNC_W-1:0] f = 5; f != 0; f++) send_word(noise_word(f));
		send_write(FUNC_HEADING, 5, 0, 0, grid_pts[1][4]);
		send_query(grid_pts[0][7], grid_pts[1][4], grid_pts[2][2]);
		send_write(FUNC_STEERING, 3, 0, 0, -32768);
		send_query(grid_pts[0][8], grid_pts[1][8], 30000);
		send_query(grid_pts[0][1], grid_pts[1][10], grid_pts[2][12]);
	endtask

	task automatic test_counts();
		logic [CNT_W-1:0] settings[6] = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd17, 5'd9};
		foreach (settings[s]) begin
			write_count(REG_LATERAL_COUNT, settings[s]);
			write_count(REG_HEADING_COUNT, settings[(s + 1) % 6]);
			write_count(REG_STEERING_COUNT, settings[(s + 2) % 6]);
			write_count(2'd3, CNT_W'($urandom));
			for (int q = 0; q < 4; q++) send_query(pick_coord(0), pick_coord(1), pick_coord(2));
		end
	endtask

	task automatic test_random();
		int r;
		for (int round = 0; round < 10; round++) begin
			drain();
			for (int a = 0; a < 3; a++) write_count(REG_W'(a), CNT_W'($urandom_range(0, 31)));
			no_gaps = (round % 4 == 3);
			for (int a = 0; a < 3; a++) load_grid(a, $urandom_range(0, 3) == 0);
			for (int n = 0; n < 50; n++) begin
				r = $urandom_range(0, 99);
				if (r < 65)
					send_query(pick_coord(0), pick_coord(1), pick_coord(2));
				else if (r < 90)
					send_write(FUNC_TABLE, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 15), VAL_W'($urandom));
				else if (r < 95)
					send_write(FUNC_W'($urandom_range(0, 2)), $urandom_range(0, LOW_POINTS - 1),
						$urandom_range(0, 15), $urandom_range(0, 15), VAL_W'($urandom));
				else
					send_word(noise_word(FUNC_W'($urandom_range(5, 7))));
			end
		end
		no_gaps = 0;
	endtask

	always @(posedge clk) begin
		out_word_t exp_cmd;
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (pending_cmds.size() == 0) begin
					$display("%0t: result with none expected, actual %h", $realtime, result);
					errors++;
				end else begin
					exp_cmd = pending_cmds.pop_front();
					if (result.steering_command !== exp_cmd.steering_command) begin
						$display("%0t: steering_command expected %0d actual %0d", $realtime,
							exp_cmd.steering_command, result.steering_command);
						errors++;
					end
					if (result.clamped !== exp_cmd.clamped) begin
						$display("%0t: clamped expected %0b actual %0b", $realtime,
							exp_cmd.clamped, result.clamped);
						errors++;
					end
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 0;
		start = 0;
		item = '0;
		reg_we = 0;
		reg_index = '0;
		reg_data = '0;
		for (int a = 0; a < 3; a++) axis_count[a] = COUNT_RESET;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_load_stores();
		test_directed();
		test_counts();
		test_random();
		drain();
		repeat (120) @(negedge clk);
		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
